>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of the PID controller.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion that is also checked while reset is high.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/cpid_pkg.sv
// Types, widths and register codes for the clamped PID controller.
// Depends on nothing; imported by every module of the block but the checker.
package cpid_pkg;

  localparam int GAIN_FRAC_BITS = 12;

  localparam int IN_W    = 16;
  localparam int ERR_W   = IN_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = 21;
  localparam int GAIN_W  = 24;
  localparam int ILIM_W  = 20;
  localparam int OLIM_W  = 15;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam int PP_W    = ERR_W + GAIN_W;
  localparam int PI_W    = SUM_W + GAIN_W;
  localparam int PD_W    = DIFF_W + GAIN_W;
  localparam int ACC_W   = PI_W + 2;
  localparam int VAL_W   = ACC_W - GAIN_FRAC_BITS;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ILIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OLIM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ESIGN = 3'd5;

  localparam logic [GAIN_W-1:0] KP_RESET   = 24'd1638400;
  localparam logic [GAIN_W-1:0] KI_RESET   = 24'd614;
  localparam logic [GAIN_W-1:0] KD_RESET   = 24'd0;
  localparam logic [ILIM_W-1:0] ILIM_RESET = 20'd20000;
  localparam logic [OLIM_W-1:0] OLIM_RESET = 15'd28000;
  localparam logic              ESIGN_RESET = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
    logic              esign;
  } cfg_t;

  // Error, clamped sum and error difference of one sample.
  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [SUM_W-1:0]  sum;
    logic [DIFF_W-1:0] diff;
  } terms_t;

  typedef struct packed {
    logic [PP_W-1:0] pp;
    logic [PI_W-1:0] pi;
    logic [PD_W-1:0] pd;
  } prods_t;

endpackage

>>> rtl/core/cpid_err.sv
// Error stage: forms the error, updates the clamped integral and the
// previous error, and registers the three terms. Uses cpid_pkg.
module cpid_err (
  input  logic                    clk,
  input  logic                    rst,
  input  cpid_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [15:0]      target,
  input  logic signed [15:0]      measured,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output cpid_pkg::terms_t        dn_terms
);
  import cpid_pkg::*;

  logic signed [ERR_W-1:0]  previous_error;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [ERR_W-1:0]  tgt_x;
  logic signed [ERR_W-1:0]  meas_x;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W:0]    lim_pos;
  logic signed [SUM_W:0]    lim_neg;
  logic signed [SUM_W:0]    sum_clamped;
  logic signed [DIFF_W-1:0] diff;
  logic                     take;

  assign in_ready = !dn_valid || dn_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    tgt_x   = ERR_W'(target);
    meas_x  = ERR_W'(measured);
    err     = cfg.esign ? (meas_x - tgt_x) : (tgt_x - meas_x);
    sum_raw = (SUM_W+1)'(integ_sum) + (SUM_W+1)'(err);
    lim_pos = {2'b00, cfg.ilim};
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = sum_raw;
    end
    diff = DIFF_W'(err) - DIFF_W'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid       <= 1'b0;
      previous_error <= '0;
      integ_sum      <= '0;
    end else begin
      if (in_ready) begin
        dn_valid <= in_valid;
      end
      if (take) begin
        previous_error <= err;
        integ_sum      <= sum_clamped[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_terms.err  <= err;
      dn_terms.sum  <= sum_clamped[SUM_W-1:0];
      dn_terms.diff <= diff;
    end
  end

endmodule

>>> rtl/core/cpid_mul.sv
// Product stage: multiplies the three terms by their gains and registers
// the products. Uses cpid_pkg.
module cpid_mul (
  input  logic              clk,
  input  logic              rst,
  input  cpid_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  cpid_pkg::terms_t  up_terms,
  output logic              dn_valid,
  input  logic              dn_ready,
  output cpid_pkg::prods_t  dn_prods
);
  import cpid_pkg::*;

  logic signed [PP_W-1:0] pp;
  logic signed [PI_W-1:0] pi;
  logic signed [PD_W-1:0] pd;

  assign up_ready = !dn_valid || dn_ready;

  // Gains are unsigned, so each gets a zero sign bit before the signed multiply.
  always_comb begin
    pp = PP_W'($signed(up_terms.err))  * PP_W'($signed({1'b0, cfg.kp}));
    pi = PI_W'($signed(up_terms.sum))  * PI_W'($signed({1'b0, cfg.ki}));
    pd = PD_W'($signed(up_terms.diff)) * PD_W'($signed({1'b0, cfg.kd}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_prods.pp <= pp;
      dn_prods.pi <= pi;
      dn_prods.pd <= pd;
    end
  end

endmodule

>>> rtl/core/cpid_sat.sv
// Output stage: adds the products, drops the fraction toward zero,
// saturates to the output limit and holds the result. Uses cpid_pkg.
module cpid_sat (
  input  logic              clk,
  input  logic              rst,
  input  cpid_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  cpid_pkg::prods_t  up_prods,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [15:0] drive,
  output logic              saturated
);
  import cpid_pkg::*;

  logic signed [ACC_W-1:0] acc_p;
  logic signed [ACC_W-1:0] acc_i;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_biased;
  logic signed [VAL_W-1:0] val;
  logic signed [VAL_W-1:0] olim_pos;
  logic signed [VAL_W-1:0] olim_neg;
  logic signed [VAL_W-1:0] val_sat;
  logic                    sat;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    acc_p = ACC_W'($signed(up_prods.pp));
    acc_i = ACC_W'($signed(up_prods.pi));
    acc_d = ACC_W'($signed(up_prods.pd));
    acc   = acc_p + acc_i + acc_d;
    // A negative sum gets the fraction mask added first so the shift rounds
    // toward zero rather than toward minus infinity.
    acc_biased = acc[ACC_W-1] ? (acc + $signed(ROUND_BIAS)) : acc;
    val      = acc_biased[ACC_W-1:GAIN_FRAC_BITS];
    olim_pos = $signed({{(VAL_W - OLIM_W){1'b0}}, cfg.olim});
    olim_neg = -olim_pos;
    if (val > olim_pos) begin
      val_sat = olim_pos;
      sat     = 1'b1;
    end else if (val < olim_neg) begin
      val_sat = olim_neg;
      sat     = 1'b1;
    end else begin
      val_sat = val;
      sat     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      drive     <= val_sat[15:0];
      saturated <= sat;
    end
  end

endmodule

>>> rtl/core/clamped_pid_controller_top.sv
// Clamped PID controller: one drive value per target/measured sample.
// Three pipeline stages (error, product, output) take 1 word/cycle unless out_ready stalls them.
// Input channel: in_valid/in_ready with target and measured (signed 16).
// Output channel: out_valid/out_ready with drive (signed 16) and saturated.
// A word is taken at a clock edge with in_valid and in_ready high; its
// result passes the error, product and output registers and then raises
// out_valid. The error stage updates the integral and previous error at
// that accept edge, so words may follow in every cycle while in_ready is high.
// Each stage holds its word while the stage after it is full and stalled, and
// empty stages keep filling; in_ready drops only when all three stages hold
// words and out_ready is low.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge
// (0 kp, 1 ki, 2 kd, 3 integral limit, 4 output limit, 5 error sign); other
// indexes are ignored. Write only while the pipeline is empty.
// Synchronous reset empties the pipeline, zeroes the integral and previous
// error, and loads the default gains and limits.
module clamped_pid_controller_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           target,
  input  logic signed [15:0]           measured,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           drive,
  output logic                         saturated,
  input  logic                         cfg_we,
  input  logic [cpid_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cpid_pkg::CFG_W-1:0]   cfg_data
);
  import cpid_pkg::*;

  cfg_t   cfg;
  terms_t terms;
  prods_t prods;
  logic   err_valid;
  logic   mul_ready;
  logic   mul_valid;
  logic   sat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp    <= KP_RESET;
      cfg.ki    <= KI_RESET;
      cfg.kd    <= KD_RESET;
      cfg.ilim  <= ILIM_RESET;
      cfg.olim  <= OLIM_RESET;
      cfg.esign <= ESIGN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:    cfg.kp    <= cfg_data[GAIN_W-1:0];
        REG_KI:    cfg.ki    <= cfg_data[GAIN_W-1:0];
        REG_KD:    cfg.kd    <= cfg_data[GAIN_W-1:0];
        REG_ILIM:  cfg.ilim  <= cfg_data[ILIM_W-1:0];
        REG_OLIM:  cfg.olim  <= cfg_data[OLIM_W-1:0];
        REG_ESIGN: cfg.esign <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cpid_err u_err (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .target   (target),
    .measured (measured),
    .dn_valid (err_valid),
    .dn_ready (mul_ready),
    .dn_terms (terms)
  );

  cpid_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (err_valid),
    .up_ready (mul_ready),
    .up_terms (terms),
    .dn_valid (mul_valid),
    .dn_ready (sat_ready),
    .dn_prods (prods)
  );

  cpid_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (mul_valid),
    .up_ready  (sat_ready),
    .up_prods  (prods),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .saturated (saturated)
  );

endmodule

>>> rtl/core/cpid_checker.sv
// Port-level checks for the clamped PID controller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cpid_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] drive,
  input logic              saturated
);

  // A stalled result keeps its value.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(saturated))

  // Every accepted sample is followed by out_valid high on the output.
  `ASSERT_CLK_RST(a_latency, clk, rst, in_valid && in_ready |-> ##3 out_valid)

  // The symmetric clamp never yields the most negative code.
  `ASSERT_CLK_RST(a_drive_range, clk, rst, out_valid |-> drive != 16'sh8000)

  // Reset empties the output stage.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind clamped_pid_controller_top cpid_checker u_cpid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive),
  .saturated (saturated)
);

>>> dv/tb_clamped_pid_controller_top.sv
// Self-checking testbench for clamped_pid_controller_top: a scoreboard class predicts
// drive and saturated for every accepted sample and checks each output word in order.
// Depends on cpid_pkg and the clamped_pid_controller_top RTL.
module tb_clamped_pid_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PIPE_SLACK = 8;
  localparam int ITEMS_PER_SETTING = 67;
  // Indexes past the last register; writes there must not change anything.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [15:0] drive;
    logic               sat;
  } drive_word_t;

  class drive_predictor;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
    logic              esign;
    longint            prev_err;
    longint            err_sum;
    drive_word_t       pending[$];
    int                mismatches;

    function new();
      kp = KP_RESET;
      ki = KI_RESET;
      kd = KD_RESET;
      ilim = ILIM_RESET;
      olim = OLIM_RESET;
      esign = ESIGN_RESET;
      prev_err = 0;
      err_sum = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KP:    kp = data;
        REG_KI:    ki = data;
        REG_KD:    kd = data;
        REG_ILIM:  ilim = data[ILIM_W-1:0];
        REG_OLIM:  olim = data[OLIM_W-1:0];
        REG_ESIGN: esign = data[0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [15:0] tgt, logic signed [15:0] meas);
      longint tv, mv, err, sum, lim, olv, gp, gi, gd, acc, val;
      bit sat;
      tv = longint'(tgt);
      mv = longint'(meas);
      lim = longint'(ilim);
      olv = longint'(olim);
      gp = longint'(kp);
      gi = longint'(ki);
      gd = longint'(kd);
      err = esign ? (mv - tv) : (tv - mv);
      // The sum is clamped after this sample's error is added, so a lowered
      // limit takes hold on the first sample that follows the write.
      sum = err_sum + err;
      if (sum > lim) sum = lim;
      else if (sum < -lim) sum = -lim;
      acc = err * gp + sum * gi + (err - prev_err) * gd;
      // Truncate toward zero, not toward minus infinity.
      if (acc < 0) val = -((-acc) >>> GAIN_FRAC_BITS);
      else val = acc >>> GAIN_FRAC_BITS;
      sat = 1'b0;
      if (val > olv) begin
        val = olv;
        sat = 1'b1;
      end else if (val < -olv) begin
        val = -olv;
        sat = 1'b1;
      end
      prev_err = err;
      err_sum = sum;
      pending.push_back('{drive: 16'(val), sat: sat});
    endfunction

    function void check_drive(logic signed [15:0] drive, logic sat);
      drive_word_t want;
      if (pending.size() == 0) begin
        $error("drive word with no sample pending: drive %0d saturated %0b", drive, sat);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", want.drive, drive);
        mismatches++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, actual %0b", want.sat, sat);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] target;
  logic signed [15:0] measured;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] drive;
  logic               saturated;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  drive_predictor sb = new();
  int send_idle_pct = 38;
  int recv_idle_pct = 87;
  int unsigned cycle_count = 0;

  clamped_pid_controller_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target(target),
    .measured(measured),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive(drive),
    .saturated(saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (!rst && in_valid && in_ready) sb.take_sample(target, measured);
    if (!rst && out_valid && out_ready) sb.check_drive(drive, saturated);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("clamped_pid_controller_top regression: fail");
      $finish;
    end
  end

  // Valid drops only ahead of a gap, so back-to-back words keep it high.
  task automatic send_sample(input logic [15:0] tgt, input logic [15:0] meas);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    target <= tgt;
    measured <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // The extra edge first lets the monitor log a word accepted at this edge.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                               input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] ilim,
                               input logic [CFG_W-1:0] olim, input logic [CFG_W-1:0] esign);
    drain_pipeline();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_ILIM, ilim);
    write_reg(REG_OLIM, olim);
    write_reg(REG_ESIGN, esign);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(4))
      0: return '0;
      1, 2: return CFG_W'($urandom_range(8192));
      3: return CFG_W'($urandom);
      default: return {CFG_W{1'b1}};
    endcase
  endfunction

  task automatic rand_settings();
    logic [CFG_W-1:0] ilim, olim;
    case ($urandom_range(3))
      0: ilim = '0;
      1: ilim = CFG_W'(20'hFFFFF);
      2: ilim = CFG_W'($urandom_range(4000));
      default: ilim = CFG_W'($urandom);
    endcase
    case ($urandom_range(3))
      0: olim = '0;
      1: olim = CFG_W'(15'h7FFF);
      2: olim = CFG_W'($urandom_range(32767, 1));
      default: olim = CFG_W'($urandom);
    endcase
    load_settings(rand_gain(), rand_gain(), rand_gain(), ilim, olim,
                  CFG_W'($urandom_range(1)));
  endtask

  // Mostly samples that track each other closely or stay near zero, so the integral moves
  // without pinning at its clamp; the rest span the full range.
  task automatic rand_sample(output logic [15:0] tgt, output logic [15:0] meas);
    case ($urandom_range(5))
      0: begin
        tgt = 16'($urandom);
        meas = 16'($urandom);
      end
      1, 2: begin
        tgt = 16'($urandom);
        meas = tgt + 16'($urandom_range(128)) - 16'd64;
      end
      3: begin
        tgt = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        meas = 16'($urandom);
      end
      default: begin
        tgt = 16'($urandom_range(600)) - 16'd300;
        meas = 16'($urandom_range(600)) - 16'd300;
      end
    endcase
  endtask

  initial begin
    int send_pcts[3];
    int recv_pcts[3];
    logic [15:0] tgt, meas;
    send_pcts = '{38, 87, 0};
    recv_pcts = '{87, 38, 0};
    rst = 1'b1;
    in_valid = 1'b0;
    target = '0;
    measured = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KP;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset gains and limits: small errors, full-scale errors, the edge of saturation.
    send_sample(16'd0, 16'd0);
    send_sample(16'd0, 16'd1);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'd100, 16'd170);

    // Unity gains and the widest integral limit: wind the sum far up.
    load_settings(24'd4096, 24'd4096, 24'd4096, 24'hFFFFF, 24'h7FFF, 24'd0);
    repeat (4) send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);

    // Lower the integral limit while the sum sits far above it.
    load_settings(24'd0, 24'hFFFFFF, 24'd0, 24'd1000, 24'h7FFF, 24'd1);
    send_sample(16'd5, 16'd2);
    send_sample(16'd2, 16'd5);

    // Zero limits with full-scale gains.
    load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    send_sample(16'd0, 16'd0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd0, 16'd1);

    // Fractional products: a negative sum must truncate toward zero.
    load_settings(24'd2049, 24'd0, 24'd0, 24'd5, 24'h7FFF, 24'd0);
    send_sample(16'd0, 16'd3);
    send_sample(16'd3, 16'd0);
    send_sample(16'h8000, 16'h7FFF);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = send_pcts[mode];
      recv_idle_pct = recv_pcts[mode];
      repeat (2) begin
        rand_settings();
        repeat (ITEMS_PER_SETTING) begin
          rand_sample(tgt, meas);
          send_sample(tgt, meas);
        end
      end
    end

    drain_pipeline();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("clamped_pid_controller_top regression: pass");
    end else begin
      $display("clamped_pid_controller_top regression: fail");
    end
    $finish;
  end

endmodule
